### design/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
`default_nettype none
package sfr_pkg;

	localparam int REG_BYTES      = 8;              // bytes held by a pattern/replacement register
	localparam int IDX_W          = $clog2(REG_BYTES);
	localparam int CNT_W          = $clog2(REG_BYTES + 1);
	localparam int CHAR_W         = 8;
	localparam int CFG_DATA_W     = REG_BYTES * CHAR_W;
	localparam int CFG_INDEX_W    = 2;
	localparam int DEF_MAX_PATTERN     = 8;
	localparam int DEF_MAX_REPLACEMENT = 8;
	localparam int DEF_QUEUE_DEPTH     = 4;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_CHARS      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_CHARS  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

	typedef logic [REG_BYTES-1:0][CHAR_W-1:0] byte_vec_t;

	// effective configuration seen by the classifier
	typedef struct packed {
		byte_vec_t        pattern;
		logic [CNT_W-1:0] plen;     // 1..min(MAX_PATTERN, 8)
		byte_vec_t        repl;
		logic [CNT_W-1:0] rlen;     // 0..min(MAX_REPLACEMENT, 8)
	} cfg_t;

	// one queued command: emit cnt bytes, or a bare end marker when cnt is zero
	typedef struct packed {
		byte_vec_t        bytes;
		logic [CNT_W-1:0] cnt;
		logic             last;
	} cmd_t;

endpackage
`default_nettype wire

### design/sfr_front.sv
// Classifier: holds the match window, compares it and builds output commands.
`default_nettype none
module sfr_front #(
	parameter int MAX_PATTERN = sfr_pkg::DEF_MAX_PATTERN
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire logic [7:0]              s_axis_tdata,
	input  wire logic                    s_axis_tlast,
	input  wire sfr_pkg::cfg_t           cfg,
	input  wire logic                    clear_win,
	output logic                         cmd_valid,
	input  wire logic                    cmd_ready,
	output sfr_pkg::cmd_t                cmd
);
	import sfr_pkg::*;

	localparam int WIN = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;

	logic [CHAR_W-1:0] win_q [WIN];
	logic [CNT_W-1:0]  fill_q;
	byte_vec_t         wn;
	byte_vec_t         wn_next;
	logic              full;
	logic              match;
	logic              accept;
	logic [CNT_W-1:0]  fill_inc;

	assign fill_inc = fill_q + CNT_W'(1);
	assign full     = (fill_inc == cfg.plen);
	assign accept   = s_axis_tvalid && cmd_ready;

	// window with the new byte placed behind the held ones
	always_comb begin
		for (int k = 0; k < REG_BYTES; k++) begin
			if (k < WIN) begin
				wn[k] = (fill_q == CNT_W'(k)) ? s_axis_tdata : win_q[k];
			end else begin
				wn[k] = '0;
			end
		end
	end

	// window advanced by one byte, oldest dropped
	assign wn_next = wn >> CHAR_W;

	always_comb begin
		match = full;
		for (int k = 0; k < REG_BYTES; k++) begin
			if ((CNT_W'(k) < cfg.plen) && (wn[k] != cfg.pattern[k])) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		cmd.last = s_axis_tlast;
		if (match) begin
			cmd.bytes = cfg.repl;
			cmd.cnt   = cfg.rlen;
		end else begin
			cmd.bytes = wn;
			if (s_axis_tlast) begin
				cmd.cnt = fill_inc;
			end else begin
				cmd.cnt = full ? CNT_W'(1) : CNT_W'(0);
			end
		end
	end

	assign s_axis_tready = cmd_ready;
	assign cmd_valid     = accept && ((cmd.cnt != '0) || s_axis_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (clear_win) begin
			fill_q <= '0;
		end else if (accept) begin
			if (s_axis_tlast || match) begin
				fill_q <= '0;
			end else if (!full) begin
				fill_q <= fill_inc;
			end
		end
	end

	// window bytes: slide when the window is full, otherwise take the new byte
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < WIN; k++) begin
				if (full) begin
					win_q[k] <= wn_next[k];
				end else begin
					win_q[k] <= wn[k];
				end
			end
		end
	end

endmodule
`default_nettype wire

### design/sfr_queue.sv
// Short command queue between the classifier and the emitter.
`default_nettype none
module sfr_queue #(
	parameter int DEPTH = sfr_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sfr_pkg::cmd_t push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               not_empty,
	output sfr_pkg::cmd_t      pop_data
);
	import sfr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [OCC_W-1:0] occ_q;

	assign full      = (occ_q == OCC_W'(DEPTH));
	assign not_empty = (occ_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (pop && !push) begin
				occ_q <= occ_q - OCC_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

### design/sfr_back.sv
// Emitter: unrolls each queued command into one output transaction per byte, or one bare end marker.
`default_nettype none
module sfr_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire sfr_pkg::cmd_t q_data,
	output logic               q_pop,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	output logic [7:0]         m_axis_tdata,
	output logic               m_axis_tlast,
	output logic               m_axis_tuser
);
	import sfr_pkg::*;

	cmd_t             cmd_q;
	logic             valid_q;
	logic [CNT_W-1:0] idx_q;
	logic             done;
	logic             fire;
	logic             advance;

	assign done    = (cmd_q.cnt == '0) || (idx_q == cmd_q.cnt - CNT_W'(1));
	assign fire    = valid_q && m_axis_tready;
	assign advance = !valid_q || (fire && done);
	assign q_pop   = advance && q_valid;

	assign m_axis_tvalid = valid_q;
	assign m_axis_tuser  = (cmd_q.cnt != '0);
	assign m_axis_tdata  = m_axis_tuser ? cmd_q.bytes[idx_q[IDX_W-1:0]] : '0;
	assign m_axis_tlast  = cmd_q.last && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= q_valid;
			idx_q   <= '0;
		end else if (fire) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
	end

endmodule
`default_nettype wire

### design/stream_find_and_replace.sv
// Top level of the streaming find-and-replace block.
//
// Usage: text bytes enter on the s_axis channel, one per transaction, with
// s_axis_tlast on the final byte of a text. Every leftmost, non-overlapping
// occurrence of the configured pattern is replaced by the replacement bytes;
// other bytes pass through unchanged. Results leave on m_axis, one byte per
// transaction, m_axis_tuser high when tdata carries a byte. A result with
// tuser low is a bare end marker (tdata zero) closing a text that produced
// no bytes on its last input. m_axis_tlast marks the final result of a text.
// Throughput: one input byte per cycle while the command queue has room; a
// byte that triggers several results (replacement or end-of-text flush, up
// to 8) holds the emitter, which gives one result per cycle while the
// receiver is ready. A command is written into the command queue when its
// byte is accepted and loaded into the emitter register once the emitter is
// free. A stalled receiver only fills the command queue; input keeps
// flowing until the queue is full.
// Reset clears the window, the queue and the emitter and loads the default
// configuration (pattern length 1, everything else zero). Write the
// configuration only while the block is idle; writing the pattern length
// empties the window.
`default_nettype none
module stream_find_and_replace #(
	parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
	parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT,
	parameter int QUEUE_DEPTH     = sfr_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [7:0]                       s_axis_tdata,  // text_char
	input  wire logic                             s_axis_tlast,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [7:0]                            m_axis_tdata,  // out_char
	output logic                                  m_axis_tlast,
	output logic                                  m_axis_tuser,  // char_valid
	input  wire logic                             cfg_we,
	input  wire logic [sfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sfr_pkg::*;

	// caps on the effective lengths: the registers hold at most 8 bytes
	localparam int PCAP = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
	localparam int RCAP = (MAX_REPLACEMENT < REG_BYTES) ? MAX_REPLACEMENT : REG_BYTES;

	logic [CFG_DATA_W-1:0] pattern_q;
	logic [3:0]            plen_q;
	logic [CFG_DATA_W-1:0] repl_q;
	logic [3:0]            rlen_q;

	cfg_t cfg;
	logic clear_win;
	logic cmd_valid;
	cmd_t cmd;
	logic q_full;
	logic q_pop;
	logic q_valid;
	cmd_t q_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= 4'd1;
			repl_q    <= '0;
			rlen_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_CHARS:      pattern_q <= cfg_data;
				REG_PATTERN_LENGTH:     plen_q    <= cfg_data[3:0];
				REG_REPLACEMENT_CHARS:  repl_q    <= cfg_data;
				REG_REPLACEMENT_LENGTH: rlen_q    <= cfg_data[3:0];
				default:                ;
			endcase
		end
	end

	assign clear_win = cfg_we && (cfg_index == REG_PATTERN_LENGTH);

	// effective lengths: zero pattern length counts as one, both clamp to their caps
	always_comb begin
		cfg.pattern = pattern_q;
		cfg.repl    = repl_q;
		if (plen_q == 4'd0) begin
			cfg.plen = CNT_W'(1);
		end else if (plen_q > 4'(PCAP)) begin
			cfg.plen = CNT_W'(PCAP);
		end else begin
			cfg.plen = CNT_W'(plen_q);
		end
		cfg.rlen = (rlen_q > 4'(RCAP)) ? CNT_W'(RCAP) : CNT_W'(rlen_q);
	end

	sfr_front #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.cfg           (cfg),
		.clear_win     (clear_win),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (!q_full),
		.cmd           (cmd)
	);

	sfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_valid),
		.push_data (cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	sfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// a bare end marker always closes a text
	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
		else $error("bare end marker without tlast");

	// a bare end marker carries a zero byte
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'h00))
		else $error("bare end marker with nonzero data");

	// the classifier never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_valid && q_full))
		else $error("command pushed into full queue");

	// the emitter never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("command popped from empty queue");

endmodule
`default_nettype wire
